[rtl/caret_color_markup_parser_macros.svh]
// Assertion macros shared by the caret color markup parser RTL.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef CARET_COLOR_MARKUP_PARSER_MACROS_SVH
`define CARET_COLOR_MARKUP_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CCMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication on the following cycle, checked outside reset.
`define CCMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ccmp_pkg.sv]
// Shared types, constants and helper functions of the caret color markup parser.
// Used by the top level, ccmp_out and ccmp_seq; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ccmp_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int PEND_AW   = $clog2(BUF_DEPTH);
  localparam int PCNT_W    = $clog2(BUF_DEPTH + 1);
  localparam int Q_AW      = $clog2(BUF_DEPTH + 1);
  localparam int Q_DEPTH   = 1 << Q_AW;
  localparam int QCNT_W    = Q_AW + 1;

  // Count of held bytes at which the sixth hex digit arrives.
  localparam logic [PCNT_W-1:0] HEX_LAST = PCNT_W'(7);

  localparam logic [2:0] MODE_PLAIN = 3'd0;
  localparam logic [2:0] MODE_CARET = 3'd1;
  localparam logic [2:0] MODE_HEX   = 3'd2;
  localparam logic [2:0] MODE_TILDE = 3'd3;

  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [23:0] WHITE = 24'hFFFFFF;

  typedef struct packed {
    logic        valid;
    logic [7:0]  ch;
    logic [23:0] color;
    logic        seg;
  } emit_t;

  typedef struct packed {
    logic valid;
    logic line_end;
  } flush_t;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Returns {valid, value}.
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  // Fixed palette, each channel is the fraction times 255, rounded.
  function automatic logic [23:0] palette(input logic [3:0] d);
    logic [23:0] c;
    unique case (d)
      4'd1:    c = 24'hFF3333;
      4'd2:    c = 24'h33FF33;
      4'd3:    c = 24'hFFFF33;
      4'd4:    c = 24'h4D8CFF;
      4'd5:    c = 24'h33FFFF;
      4'd6:    c = 24'hFF4DFF;
      4'd8:    c = 24'hBF2626;
      4'd9:    c = 24'h8C8C8C;
      default: c = WHITE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/caret_color_markup_parser.sv]
// Caret color markup parser: strips caret color codes and hidden tilde runs
// from a text line and tags every kept character with its RGB color.
// Channels: s_tvalid/s_tready/s_tdata/s_tlast takes one text byte per transaction,
// s_tlast marking the final byte of the line. m_tvalid/m_tready/m_tdata/m_tuser/
// m_tlast gives zero or more results per input; m_tlast marks the last result of
// that input, m_tuser[1] the final result of the line, m_tuser[0] a real character.
// A line end that releases no character gives one bare marker result.
// Steps: an input is accepted, then each byte is parsed by a queue read and a
// decide step; an empty-queue check and a finishing step end the input. A held
// run that is replayed emits its first byte literally and puts the others back
// in the queue to be parsed again; it is bounded by the 32-entry buffer, and the
// work queue memory has a single read port. A kept character waits in a staging
// register until the next one or the end of its input is decided. s_tready is
// high only between inputs.
// Reset (rst, synchronous) returns to plain text mode, white, with a segment start
// pending; the memories need no clearing. When the receiver stalls, the parser
// waits at its next result; it may accept a new input while the last result waits.
`timescale 1ns / 1ps
`default_nettype none
module caret_color_markup_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // char_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // out_char, red, green, blue, new_segment, zero pad
  output logic [1:0]       m_tuser,   // char_valid, line_done
  output logic             m_tlast    // run_last
);

  ccmp_pkg::emit_t  emit;
  ccmp_pkg::flush_t flush;
  logic             busy;

  ccmp_seq u_seq (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .busy(busy), .emit(emit), .flush(flush)
  );

  ccmp_out u_out (
    .clk(clk), .rst(rst), .emit(emit), .flush(flush), .busy(busy),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule
`default_nettype wire

[rtl/ccmp_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module ccmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/ccmp_out.sv]
// Result staging: holds the newest kept character until it is known whether it
// is the last result of its input, then moves it into the output register.
// Depends on ccmp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
module ccmp_out (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ccmp_pkg::emit_t  emit,
  input  wire ccmp_pkg::flush_t flush,
  output logic                busy,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [39:0]         m_tdata,   // out_char, red, green, blue, new_segment, zero pad
  output logic [1:0]          m_tuser,   // char_valid, line_done
  output logic                m_tlast    // run_last
);

  logic        staged_valid;
  logic [7:0]  staged_ch;
  logic [23:0] staged_color;
  logic        staged_seg;
  logic        load_mid;
  logic        load_end;
  logic        load_mark;

  assign busy      = m_tvalid && !m_tready;
  assign load_mid  = emit.valid && staged_valid;
  assign load_end  = !emit.valid && flush.valid && staged_valid;
  assign load_mark = !emit.valid && flush.valid && !staged_valid && flush.line_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      staged_valid <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (load_mid || load_end || load_mark) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (emit.valid) begin
        if (staged_valid) begin
          m_tdata  <= {7'd0, staged_seg, staged_color[7:0], staged_color[15:8],
                       staged_color[23:16], staged_ch};
          m_tuser  <= 2'b01;
          m_tlast  <= 1'b0;
        end
        staged_valid <= 1'b1;
        staged_ch    <= emit.ch;
        staged_color <= emit.color;
        staged_seg   <= emit.seg;
      end else if (flush.valid) begin
        staged_valid <= 1'b0;
        if (staged_valid) begin
          m_tdata  <= {7'd0, staged_seg, staged_color[7:0], staged_color[15:8],
                       staged_color[23:16], staged_ch};
          m_tuser  <= {flush.line_end, 1'b1};
          m_tlast  <= 1'b1;
        end else if (flush.line_end) begin
          // Line end that released nothing: bare marker.
          m_tdata  <= 40'd0;
          m_tuser  <= 2'b10;
          m_tlast  <= 1'b1;
        end
      end
    end
  end

`include "caret_color_markup_parser_macros.svh"
  `CCMP_ASSERT_NOW(a_no_emit_flush, emit.valid, !flush.valid, "emit and flush together")
  `CCMP_ASSERT_NOW(a_no_write_stall, emit.valid || flush.valid, !busy, "write while stalled")
  `CCMP_ASSERT_NEXT(a_flush_empties, flush.valid, !staged_valid, "staged result not flushed")

endmodule
`default_nettype wire

[rtl/ccmp_seq.sv]
// Parsing sequencer: work queue and pending buffer memories, mode, color and
// replay control. Depends on ccmp_pkg, ccmp_ram and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
module ccmp_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [7:0]      s_tdata,   // char_byte
  input  wire logic            s_tlast,   // last_byte
  input  wire logic            busy,
  output ccmp_pkg::emit_t      emit,
  output ccmp_pkg::flush_t     flush
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_FETCH    = 3'd1;
  localparam logic [2:0] ST_DECIDE   = 3'd2;
  localparam logic [2:0] ST_REL_EMIT = 3'd3;
  localparam logic [2:0] ST_REL_PUSH = 3'd4;
  localparam logic [2:0] ST_FINISH   = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] mode, mode_next;
  logic [ccmp_pkg::PCNT_W-1:0] pcount, pcount_next;
  logic [ccmp_pkg::PCNT_W-1:0] idx, idx_next;
  logic [ccmp_pkg::Q_AW-1:0]   head, head_next;
  logic [ccmp_pkg::QCNT_W-1:0] qcount, qcount_next;
  logic [23:0] color, color_next;
  logic [23:0] hexacc, hexacc_next;
  logic        brk, brk_next;
  logic        line_end, line_end_next;

  logic                        q_we;
  logic [ccmp_pkg::Q_AW-1:0]   q_waddr;
  logic [7:0]                  q_wdata, q_rdata;
  logic                        p_we;
  logic [ccmp_pkg::PEND_AW-1:0] p_raddr;
  logic [7:0]                  p_rdata;
  logic [4:0]                  hv;
  logic [23:0]                 hex_new;

  ccmp_ram #(.WIDTH(8), .DEPTH(ccmp_pkg::Q_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head), .rdata(q_rdata)
  );

  ccmp_ram #(.WIDTH(8), .DEPTH(ccmp_pkg::BUF_DEPTH)) u_pend (
    .clk(clk), .we(p_we), .waddr(pcount[ccmp_pkg::PEND_AW-1:0]), .wdata(q_rdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign hv       = ccmp_pkg::hex_nibble(q_rdata);
  assign hex_new  = {hexacc[19:0], hv[3:0]};

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    pcount_next   = pcount;
    idx_next      = idx;
    head_next     = head;
    qcount_next   = qcount;
    color_next    = color;
    hexacc_next   = hexacc;
    brk_next      = brk;
    line_end_next = line_end;
    q_we          = 1'b0;
    q_waddr       = head;
    q_wdata       = s_tdata;
    p_we          = 1'b0;
    p_raddr       = '0;
    emit          = '0;
    flush         = '0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          q_we          = 1'b1;
          qcount_next   = ccmp_pkg::QCNT_W'(1);
          line_end_next = s_tlast;
          state_next    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (qcount != '0) begin
          state_next = ST_DECIDE;
        end else if (line_end && mode != ccmp_pkg::MODE_PLAIN) begin
          // Unresolved held bytes at line end are replayed.
          if (pcount == '0) begin
            mode_next = ccmp_pkg::MODE_PLAIN;
          end else begin
            idx_next   = pcount - 1'b1;
            state_next = ST_REL_EMIT;
          end
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DECIDE: begin
        logic pop, rel;
        pop = 1'b1;
        rel = 1'b0;
        priority case (mode)
          ccmp_pkg::MODE_CARET: begin
            if (q_rdata == ccmp_pkg::CH_HASH) begin
              p_we        = 1'b1;
              pcount_next = pcount + 1'b1;
              mode_next   = ccmp_pkg::MODE_HEX;
              hexacc_next = '0;
            end else if (ccmp_pkg::is_digit(q_rdata)) begin
              color_next  = ccmp_pkg::palette(q_rdata[3:0]);
              brk_next    = 1'b1;
              mode_next   = ccmp_pkg::MODE_PLAIN;
              pcount_next = '0;
            end else if (q_rdata == ccmp_pkg::CH_R || q_rdata == ccmp_pkg::CH_TILDE) begin
              color_next  = ccmp_pkg::WHITE;
              brk_next    = 1'b1;
              mode_next   = ccmp_pkg::MODE_PLAIN;
              pcount_next = '0;
            end else if (q_rdata == ccmp_pkg::CH_STAR || q_rdata == ccmp_pkg::CH_UNDER) begin
              mode_next   = ccmp_pkg::MODE_PLAIN;
              pcount_next = '0;
            end else begin
              rel = 1'b1;
            end
          end
          ccmp_pkg::MODE_HEX: begin
            if (hv[4]) begin
              p_we        = 1'b1;
              pcount_next = pcount + 1'b1;
              hexacc_next = hex_new;
              if (pcount == ccmp_pkg::HEX_LAST) begin
                color_next  = hex_new;
                brk_next    = 1'b1;
                mode_next   = ccmp_pkg::MODE_PLAIN;
                pcount_next = '0;
              end
            end else begin
              rel = 1'b1;
            end
          end
          ccmp_pkg::MODE_TILDE: begin
            if (q_rdata == ccmp_pkg::CH_TILDE) begin
              mode_next   = ccmp_pkg::MODE_PLAIN;
              pcount_next = '0;
            end else if (pcount < ccmp_pkg::PCNT_W'(ccmp_pkg::BUF_DEPTH)) begin
              p_we        = 1'b1;
              pcount_next = pcount + 1'b1;
            end else begin
              rel = 1'b1;
            end
          end
          default: begin
            if (q_rdata == ccmp_pkg::CH_CARET || q_rdata == ccmp_pkg::CH_TILDE) begin
              // Held byte goes to entry zero; the count is set to one here.
              p_we        = 1'b1;
              pcount_next = ccmp_pkg::PCNT_W'(1);
              mode_next   = (q_rdata == ccmp_pkg::CH_CARET) ? ccmp_pkg::MODE_CARET
                                                            : ccmp_pkg::MODE_TILDE;
            end else if (busy) begin
              pop = 1'b0;
              p_we = 1'b0;
            end else begin
              emit.valid  = 1'b1;
              emit.ch     = q_rdata;
              emit.color  = color;
              emit.seg    = brk;
              brk_next    = 1'b0;
              mode_next   = ccmp_pkg::MODE_PLAIN;
              pcount_next = '0;
            end
          end
        endcase
        if (rel) begin
          // The byte stays at the queue head and is parsed again after the replay.
          pop = 1'b0;
          if (pcount == '0) begin
            mode_next  = ccmp_pkg::MODE_PLAIN;
            state_next = ST_FETCH;
          end else begin
            idx_next   = pcount - 1'b1;
            state_next = ST_REL_EMIT;
          end
        end else if (pop) begin
          head_next   = head + 1'b1;
          qcount_next = qcount - 1'b1;
          state_next  = ST_FETCH;
        end
        if (mode != ccmp_pkg::MODE_PLAIN && mode != ccmp_pkg::MODE_CARET &&
            mode != ccmp_pkg::MODE_HEX && mode != ccmp_pkg::MODE_TILDE &&
            q_rdata == ccmp_pkg::CH_CARET) begin
          p_we = 1'b1;
        end
      end
      ST_REL_EMIT: begin
        // The first held byte is kept literally.
        if (busy) begin
          p_raddr = '0;
        end else begin
          p_raddr     = idx[ccmp_pkg::PEND_AW-1:0];
          emit.valid  = 1'b1;
          emit.ch     = p_rdata;
          emit.color  = color;
          emit.seg    = brk;
          brk_next    = 1'b0;
          mode_next   = ccmp_pkg::MODE_PLAIN;
          pcount_next = '0;
          state_next  = (idx == '0) ? ST_FETCH : ST_REL_PUSH;
        end
      end
      ST_REL_PUSH: begin
        // Held bytes go back in front of the queue, last one first.
        q_we        = 1'b1;
        q_waddr     = head - 1'b1;
        q_wdata     = p_rdata;
        head_next   = head - 1'b1;
        qcount_next = qcount + 1'b1;
        idx_next    = idx - 1'b1;
        p_raddr     = idx_next[ccmp_pkg::PEND_AW-1:0];
        if (idx_next == '0) state_next = ST_FETCH;
      end
      ST_FINISH: begin
        if (!busy) begin
          flush.valid    = 1'b1;
          flush.line_end = line_end;
          if (line_end) begin
            color_next = ccmp_pkg::WHITE;
            brk_next   = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= ccmp_pkg::MODE_PLAIN;
      pcount   <= '0;
      idx      <= '0;
      head     <= '0;
      qcount   <= '0;
      color    <= ccmp_pkg::WHITE;
      hexacc   <= '0;
      brk      <= 1'b1;
      line_end <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      pcount   <= pcount_next;
      idx      <= idx_next;
      head     <= head_next;
      qcount   <= qcount_next;
      color    <= color_next;
      hexacc   <= hexacc_next;
      brk      <= brk_next;
      line_end <= line_end_next;
    end
  end

`include "caret_color_markup_parser_macros.svh"
  `CCMP_ASSERT_NOW(a_idle_queue_empty, state == ST_IDLE, qcount == '0, "queue not empty when idle")
  `CCMP_ASSERT_NOW(a_pend_bound, 1'b1, pcount <= ccmp_pkg::PCNT_W'(ccmp_pkg::BUF_DEPTH), "pending overflow")
  `CCMP_ASSERT_NOW(a_queue_room, state == ST_REL_PUSH, qcount < ccmp_pkg::QCNT_W'(ccmp_pkg::Q_DEPTH), "queue overflow")

endmodule
`default_nettype wire
